>>> rtl/sfr_pkg.sv
// Shared types and constants for the serial bus frame receiver.
// No dependencies; imported by the framer, the channel emitter and the top level.
package sfr_pkg;

    // Frame geometry
    localparam int FRAME_BYTES    = 25;
    localparam int DATA_BYTES     = 22;                  // bytes 1..22 carry channel bits
    localparam int NUM_CHANNELS   = 16;
    localparam int CHANNEL_BITS   = 11;
    localparam int PAYLOAD_BITS   = DATA_BYTES * 8;      // equals NUM_CHANNELS * CHANNEL_BITS
    localparam int POS_BITS       = 5;
    localparam int CHAN_IDX_BITS  = 4;
    localparam int COUNT_BITS     = 16;

    localparam logic [POS_BITS-1:0]      END_POS      = POS_BITS'(FRAME_BYTES - 1);
    localparam logic [CHAN_IDX_BITS-1:0] LAST_CHANNEL = CHAN_IDX_BITS'(NUM_CHANNELS - 1);

    // Mask applied to the end byte before comparing with the end value
    localparam logic [7:0] END_MASK = 8'h04;

    // Configuration register indexes
    localparam logic REG_START_VALUE = 1'b0;
    localparam logic REG_END_VALUE   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] START_VALUE_RST = 8'h0f;
    localparam logic [7:0] END_VALUE_RST   = 8'h00;

    // A completed, accepted frame handed from the framer to the emitter
    typedef struct packed {
        logic                    valid;
        logic [PAYLOAD_BITS-1:0] payload;   // byte 1 in the lowest bits
        logic [COUNT_BITS-1:0]   count;     // accepted frames including this one
    } frame_load_t;

endpackage

>>> rtl/sfr_framer.sv
// Byte framer: hunts for the start byte, stores data bytes, checks the end byte.
// Depends on sfr_pkg; feeds sfr_emitter with one load per accepted frame.
module sfr_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 emit_busy,
    output sfr_pkg::frame_load_t load
);
    import sfr_pkg::*;

    logic [7:0]            start_value_reg;
    logic [7:0]            end_value_reg;
    logic                  hunting_reg, hunting_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [COUNT_BITS-1:0] frames_reg, frames_next;
    logic [7:0]            data_reg [DATA_BYTES];
    logic                  accept;
    logic                  at_end;
    logic                  frame_ok;

    // The end byte waits only while the emitter still holds the previous frame.
    assign at_end   = !hunting_reg && (pos_reg >= END_POS);
    assign s_tready = !(at_end && emit_busy);
    assign accept   = s_tvalid && s_tready;
    assign frame_ok = accept && !hunting_reg && (pos_reg == END_POS)
                      && ((s_tdata & END_MASK) == end_value_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_value_reg <= START_VALUE_RST;
            end_value_reg   <= END_VALUE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_VALUE: start_value_reg <= cfg_wdata;
                REG_END_VALUE:   end_value_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Framing state
    always_comb begin
        hunting_next = hunting_reg;
        pos_next     = pos_reg;
        frames_next  = frames_reg;
        if (accept) begin
            if (hunting_reg) begin
                if (s_tdata == start_value_reg) begin
                    hunting_next = 1'b0;
                    pos_next     = POS_BITS'(1);
                end
            end else if (pos_reg < END_POS) begin
                pos_next = pos_reg + POS_BITS'(1);
            end else begin
                // End byte, or a position that cannot occur: hunt again.
                hunting_next = 1'b1;
                pos_next     = '0;
                if (frame_ok) begin
                    frames_next = frames_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_reg <= 1'b1;
            pos_reg     <= '0;
            frames_reg  <= '0;
        end else begin
            hunting_reg <= hunting_next;
            pos_reg     <= pos_next;
            frames_reg  <= frames_next;
        end
    end

    // Data byte store: byte position i+1 lands in entry i.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DATA_BYTES; i++) begin
            if (accept && !hunting_reg && (pos_reg == POS_BITS'(i + 1))) begin
                data_reg[i] <= s_tdata;
            end
        end
    end

    // Hand the accepted frame to the emitter in the same cycle as the end byte.
    always_comb begin
        load.valid = frame_ok;
        load.count = frames_next;
        for (int i = 0; i < DATA_BYTES; i++) begin
            load.payload[8*i +: 8] = data_reg[i];
        end
    end

endmodule

>>> rtl/sfr_emitter.sv
// Channel emitter: holds one accepted frame and sends its sixteen channels.
// Depends on sfr_pkg; loaded by sfr_framer.
module sfr_emitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfr_pkg::frame_load_t load,
    output logic                 emit_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // channel_index[3:0], channel_value[14:4],
                                            // frame_count[30:15], zero pad [31]
    output logic                 m_tlast    // last_channel
);
    import sfr_pkg::*;

    logic                     busy_reg;
    logic [CHAN_IDX_BITS-1:0] chan_reg;
    logic [PAYLOAD_BITS-1:0]  buf_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic                     take;

    assign take = busy_reg && m_tready;

    // Busy flag: set on load, cleared once the last channel item is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load.valid) begin
            busy_reg <= 1'b1;
        end else if (take && (chan_reg == LAST_CHANNEL)) begin
            busy_reg <= 1'b0;
        end
    end

    // Frame buffer shifts one channel down for every item taken.
    always_ff @(posedge aclk) begin
        if (load.valid) begin
            buf_reg   <= load.payload;
            count_reg <= load.count;
            chan_reg  <= '0;
        end else if (take) begin
            buf_reg  <= buf_reg >> CHANNEL_BITS;
            chan_reg <= chan_reg + CHAN_IDX_BITS'(1);
        end
    end

    assign emit_busy = busy_reg;
    assign m_tvalid  = busy_reg;
    assign m_tlast   = (chan_reg == LAST_CHANNEL);
    assign m_tdata   = {1'b0, count_reg, buf_reg[CHANNEL_BITS-1:0], chan_reg};

endmodule

>>> rtl/sbus_frame_receiver.sv
// Serial bus frame receiver top level: framer plus channel emitter.
// Depends on sfr_pkg, sfr_framer and sfr_emitter.
//
// Takes one received byte per cycle. While hunting, a byte equal to start_value
// (register 0) opens a 25-byte frame; bytes 1 to 22 are kept, and byte 24 is the
// end byte. If the end byte ANDed with 0x04 equals end_value (register 1), the
// frame counter increments and sixteen items follow, one per cycle the output is
// ready, each carrying a channel index, its 11-bit value and the frame count, with
// tlast on channel 15. A bad end byte emits nothing and the block hunts again.
// Input bytes flow at one per cycle unless the end byte is held off. An accepted
// frame occupies the output until the emitter's shift buffer is empty; the end
// byte of a following frame is held off only while that buffer is not yet drained.
module sbus_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // channel_index[3:0], channel_value[14:4],
                                    // frame_count[30:15], zero pad [31]
    output logic        m_tlast     // last_channel
);
    import sfr_pkg::*;

    frame_load_t load;
    logic        emit_busy;

    sfr_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .emit_busy (emit_busy),
        .load      (load)
    );

    sfr_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .emit_busy (emit_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sbus_frame_receiver. It streams received bytes into
// the block and checks every decoded channel item against a frame decoder kept here.
// Depends on sfr_pkg and the sbus_frame_receiver RTL; reads no files.

module testbench;
    import sfr_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 24;     // settle time once every channel item is out
    localparam int LONG_HOLD    = 300;    // receiver hold-off that backs up the framer
    localparam int BODY_BITS    = (FRAME_BYTES - 2) * 8;

    // One decoded channel as it should leave the block
    typedef struct {
        logic [3:0]  index;
        logic [10:0] value;
        logic        is_last;
        logic [15:0] count;
    } channel_item_t;

    // Frame decoder that tracks the block and holds the channel items still owed
    class sbus_checker;
        logic [7:0]    start_val;
        logic [7:0]    end_val;
        bit            hunting;
        logic [4:0]    position;
        logic [7:0]    frame_bytes [FRAME_BYTES];
        logic [15:0]   accepted;
        channel_item_t channels_due [$];
        int            mismatches;

        function new();
            start_val  = START_VALUE_RST;
            end_val    = END_VALUE_RST;
            hunting    = 1'b1;
            position   = '0;
            accepted   = '0;
            mismatches = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        endfunction

        function void set_register(logic idx, logic [7:0] value);
            if (idx == REG_START_VALUE) start_val = value;
            else end_val = value;
        endfunction

        function int pending();
            return channels_due.size();
        endfunction

        // Note one accepted byte and queue the channels of a frame it completes.
        function void take_byte(logic [7:0] b);
            logic [PAYLOAD_BITS-1:0] payload;
            channel_item_t           item;
            if (hunting) begin
                if (b == start_val) begin
                    frame_bytes[0] = b;
                    position = 5'd1;
                    hunting = 1'b0;
                end
                return;
            end
            frame_bytes[position] = b;
            if (position != END_POS) begin
                position = position + 1'b1;
                return;
            end
            // End byte: the block hunts again whatever the outcome.
            hunting = 1'b1;
            position = '0;
            if ((b & END_MASK) != end_val) return;
            accepted = accepted + 1'b1;
            for (int i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = frame_bytes[i + 1];
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                item.index   = 4'(k);
                item.value   = payload[CHANNEL_BITS*k +: CHANNEL_BITS];
                item.is_last = (k == NUM_CHANNELS - 1);
                item.count   = accepted;
                channels_due.push_back(item);
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Check one channel item taken from the output against the oldest one owed.
        function void check_channel(logic [31:0] data, logic tlast);
            channel_item_t want;
            if (channels_due.size() == 0) begin
                $display("%0t: channel item with none expected, expected nothing, actual %h/%b",
                         $time, data, tlast);
                mismatches++;
                return;
            end
            want = channels_due.pop_front();
            compare_field("channel_index", 16'(want.index), 16'(data[3:0]));
            compare_field("channel_value", 16'(want.value), 16'(data[14:4]));
            compare_field("frame_count", want.count, data[30:15]);
            compare_field("last_channel", 16'(want.is_last), 16'(tlast));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sbus_checker sb;
    int          tx_idle_pct = 13;
    int          rx_idle_pct = 63;
    bit          long_hold_req = 1'b0;
    int          quiet_cycles = 0;

    sbus_frame_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Output side: check every channel item taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_channel(m_tdata, m_tlast);
    end

    // Receiver readiness, with a long hold-off when the stimulus asks for one.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one byte, sometimes after a random gap, and note it once accepted.
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b);
    endtask

    // Start byte, bytes 1 to 23 from the body (byte 1 lowest), then the end byte.
    task automatic send_frame(input logic [BODY_BITS-1:0] body, input logic [7:0] tail_byte);
        send_byte(sb.start_val);
        for (int i = 0; i < FRAME_BYTES - 2; i++) send_byte(body[8*i +: 8]);
        send_byte(tail_byte);
    endtask

    // Random frame body; now and then a data byte equals the start value.
    function automatic logic [BODY_BITS-1:0] random_body();
        logic [BODY_BITS-1:0] body;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            body[8*i +: 8] = ($urandom_range(0, 9) == 0) ? sb.start_val : 8'($urandom);
        return body;
    endfunction

    // Random end byte whose masked bit matches the end value or not. An end value
    // with other bits set cannot match, so any byte will do then.
    function automatic logic [7:0] pick_end_byte(input bit good);
        logic [7:0] b;
        b = 8'($urandom);
        if (sb.end_val == 8'h00 || sb.end_val == END_MASK)
            b = (b & ~END_MASK) | (good ? sb.end_val : (sb.end_val ^ END_MASK));
        return b;
    endfunction

    // Stop offering, wait until every channel item is out, then settle.
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Bring the framer back to hunting with a failing end byte, drain, then write.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        while (!sb.hunting) begin
            if (sb.position == END_POS)
                send_byte((sb.end_val == 8'h00) ? END_MASK : 8'h00);
            else
                send_byte(8'($urandom));
        end
        drain(DRAIN_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed frames, with line noise and cut-off frames mixed in.
    task automatic random_traffic(input int target);
        int done;
        int pick;
        int n;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(random_body(), pick_end_byte($urandom_range(0, 99) < 80));
                done += FRAME_BYTES;
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                n = $urandom_range(1, 20);
                send_byte(sb.start_val);
                repeat (n) send_byte(8'($urandom));
                done += n + 1;
            end
        end
    endtask

    initial begin
        logic [BODY_BITS-1:0] body;

        sb = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_START_VALUE;
        cfg_wdata <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly, receiver heavily. Directed, reset settings: bytes
        // while hunting, an all-ones frame with the start value as data, and an
        // all-zeros frame.
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'hf0);
        body = {(FRAME_BYTES - 2){8'hff}};
        body[8*(FRAME_BYTES - 3) +: 8] = START_VALUE_RST;
        send_frame(body, 8'h00);
        send_frame('0, 8'hfb);

        // One long receiver hold-off while two good frames back up the block.
        write_reg(REG_START_VALUE, 8'h00);
        write_reg(REG_END_VALUE, END_MASK);
        long_hold_req = 1'b1;
        repeat (2) send_frame(random_body(), pick_end_byte(1'b1));

        // Roles swapped; the sender waits once for every channel item to come out.
        write_reg(REG_START_VALUE, 8'hff);
        write_reg(REG_END_VALUE, 8'h00);
        tx_idle_pct = 63;
        rx_idle_pct = 13;
        random_traffic(20);
        drain(0);

        // No idling; a good frame, then an end value that can never match.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_START_VALUE, 8'($urandom));
        send_frame(random_body(), pick_end_byte(1'b1));
        write_reg(REG_END_VALUE, 8'hff);
        send_frame(random_body(), pick_end_byte(1'b1));

        drain(40);
        if (sb.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sfr_pkg.sv
rtl/sfr_framer.sv
rtl/sfr_emitter.sv
rtl/sbus_frame_receiver.sv
verif/testbench.sv
